// ===== hw/rtl/rmc_pkg.sv =====
// Shared types, constants and helper functions of the rectangular maze carver.
package rmc_pkg;

    localparam int GRID_ROWS = 16;
    localparam int GRID_COLS = 16;
    localparam int CELL_CAP  = GRID_ROWS * GRID_COLS;
    localparam int DEPTH_W   = $clog2(CELL_CAP + 1);
    localparam int SP_W      = $clog2(CELL_CAP);
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_SHUFFLE = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic WALL_HORIZ = 1'b0;
    localparam logic WALL_VERT  = 1'b1;

    typedef enum logic [1:0] {
        STAT_CARVED  = 2'd0,
        STAT_DONE    = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef logic [3:0][1:0] order_t;

    localparam order_t ORDER_INIT = {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};

    // One stacked cell: position, direction order and next slot to try.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        order_t           order;
        logic [2:0]       next;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    typedef struct packed {
        logic             in_grid;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } nbr_t;

    // Fisher-Yates order: slot 3, then slot 2, then slot 1.
    function automatic order_t shuffle_order(logic [1:0] p3, logic [1:0] p2, logic p1);
        order_t     o;
        logic [1:0] t;
        logic [1:0] p2s;
        o   = ORDER_INIT;
        p2s = (p2 > 2'd2) ? 2'd2 : p2;
        t = o[3]; o[3] = o[p3]; o[p3] = t;
        t = o[2]; o[2] = o[p2s]; o[p2s] = t;
        t = o[1]; o[1] = o[{1'b0, p1}]; o[{1'b0, p1}] = t;
        return o;
    endfunction

    function automatic nbr_t neighbor(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                      logic [1:0] d);
        nbr_t n;
        n.row = r;
        n.col = c;
        n.in_grid = 1'b1;
        unique case (d)
            DIR_UP: begin
                n.in_grid = (r != '0);
                n.row     = r - 1'b1;
            end
            DIR_DOWN: begin
                n.in_grid = (r != ROW_W'(GRID_ROWS - 1));
                n.row     = r + 1'b1;
            end
            DIR_LEFT: begin
                n.in_grid = (c != '0);
                n.col     = c - 1'b1;
            end
            default: begin
                n.in_grid = (c != COL_W'(GRID_COLS - 1));
                n.col     = c + 1'b1;
            end
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/rectangular_maze_carver_unit.sv =====
// Top level of the depth-first maze carver with stack and visited map in RAM.
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | tuser: req_type; tdata: start cell and three picks
//  m_      | out | m_tvalid/m_tready  | tuser: status; tdata: removed wall and new cell
//
// A request is accepted in idle; the engine then tries one direction at a time, reads
// the visited RAM for each in-grid neighbor, spends an exhausted try and a stack RAM
// reload on each cell popped off the stack, and takes a final step for the last cell
// when the maze finishes; a long backtrack takes longer than a short carve.
// The result register frees the input: a new request is taken once the engine is idle
// and the result slot is empty or being drained. A stalled result holds the engine
// at its final step. Reset clears control state only; a start request clears the
// visited map at once through per-row valid flags, so no clearing pass is needed.
module rectangular_maze_carver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // start_row[3:0], start_col[7:4], pick_three[9:8],
                                   // pick_two[11:10], pick_one[12], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // wall_kind[0], wall_row[5:1], wall_col[10:6],
                                   // cell_row[14:11], cell_col[18:15], zero pad
    output logic [1:0]  m_tuser    // status
);
    import rmc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_TRY   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_LOAD  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    frame_t                 top_reg, top_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic                   in_prog_reg, in_prog_next;
    logic [1:0]             dir_reg, dir_next;
    logic [GRID_ROWS-1:0]   row_valid_reg, row_valid_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                status_reg, status_next;
    logic                   kind_reg, kind_next;
    logic [4:0]             wrow_reg, wrow_next;
    logic [4:0]             wcol_reg, wcol_next;
    logic [ROW_W-1:0]       crow_reg, crow_next;
    logic [COL_W-1:0]       ccol_reg, ccol_next;

    // visited map: one row of flags per entry
    logic                   vis_rd_en, vis_wr_en;
    logic [ROW_W-1:0]       vis_rd_addr, vis_wr_addr;
    logic [GRID_COLS-1:0]   vis_rdata, vis_wdata;

    // path stack: entries below the top frame, which lives in top_reg
    logic                   stk_rd_en, stk_wr_en;
    logic [SP_W-1:0]        stk_rd_addr, stk_wr_addr;
    logic [FRAME_W-1:0]     stk_rdata, stk_wdata;

    logic                   s_accept;
    logic                   out_free;
    logic [1:0]             cur_dir;
    nbr_t                   nb_try, nb_chk;
    logic [GRID_COLS-1:0]   vis_row;
    logic                   vis_hit;
    logic [ROW_W-1:0]       start_r;
    logic [COL_W-1:0]       start_c;
    order_t                 picked;

    rmc_ram #(.DATA_W(GRID_COLS), .DEPTH(GRID_ROWS)) u_visited (
        .aclk    (aclk),
        .wr_en   (vis_wr_en),
        .wr_addr (vis_wr_addr),
        .wr_data (vis_wdata),
        .rd_en   (vis_rd_en),
        .rd_addr (vis_rd_addr),
        .rd_data (vis_rdata)
    );

    rmc_ram #(.DATA_W(FRAME_W), .DEPTH(CELL_CAP)) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wdata),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    // clamp the start cell into the grid
    assign start_r = (s_tdata[3:0] > ROW_W'(GRID_ROWS - 1)) ? ROW_W'(GRID_ROWS - 1)
                                                             : s_tdata[3:0];
    assign start_c = (s_tdata[7:4] > COL_W'(GRID_COLS - 1)) ? COL_W'(GRID_COLS - 1)
                                                             : s_tdata[7:4];
    assign picked  = shuffle_order(s_tdata[9:8], s_tdata[11:10], s_tdata[12]);

    assign cur_dir = top_reg.order[top_reg.next[1:0]];
    assign nb_try  = neighbor(top_reg.row, top_reg.col, cur_dir);
    assign nb_chk  = neighbor(top_reg.row, top_reg.col, dir_reg);
    // a row not written since the last start reads as all unvisited
    assign vis_row = row_valid_reg[nb_chk.row] ? vis_rdata : '0;
    assign vis_hit = vis_row[nb_chk.col];

    always_comb begin
        state_next     = state_reg;
        top_next       = top_reg;
        depth_next     = depth_reg;
        in_prog_next   = in_prog_reg;
        dir_next       = dir_reg;
        row_valid_next = row_valid_reg;

        m_valid_next   = m_valid_reg && !m_tready;
        status_next    = status_reg;
        kind_next      = kind_reg;
        wrow_next      = wrow_reg;
        wcol_next      = wcol_reg;
        crow_next      = crow_reg;
        ccol_next      = ccol_reg;

        vis_rd_en   = 1'b0;
        vis_rd_addr = nb_try.row;
        vis_wr_en   = 1'b0;
        vis_wr_addr = nb_chk.row;
        vis_wdata   = vis_row;
        stk_rd_en   = 1'b0;
        stk_rd_addr = SP_W'(depth_reg - DEPTH_W'(2));
        stk_wr_en   = 1'b0;
        stk_wr_addr = SP_W'(depth_reg - DEPTH_W'(1));
        stk_wdata   = top_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (s_tuser == REQ_START) begin
                        // abandon any maze, clear the map and seed the start cell
                        row_valid_next          = '0;
                        row_valid_next[start_r] = 1'b1;
                        vis_wr_en               = 1'b1;
                        vis_wr_addr             = start_r;
                        vis_wdata               = '0;
                        vis_wdata[start_c]      = 1'b1;
                        top_next.row            = start_r;
                        top_next.col            = start_c;
                        top_next.order          = picked;
                        top_next.next           = '0;
                        depth_next              = DEPTH_W'(1);
                        in_prog_next            = 1'b1;
                        state_next              = ST_TRY;
                    end else if (!in_prog_reg || depth_reg == '0) begin
                        m_valid_next = 1'b1;
                        status_next  = STAT_IGNORED;
                        kind_next    = WALL_HORIZ;
                        wrow_next    = '0;
                        wcol_next    = '0;
                        crow_next    = '0;
                        ccol_next    = '0;
                    end else begin
                        top_next.order = picked;
                        top_next.next  = '0;
                        state_next     = ST_TRY;
                    end
                end
            end
            ST_TRY: begin
                if (top_reg.next[2]) begin
                    // all four directions tried: drop this cell
                    if (depth_reg == DEPTH_W'(1)) begin
                        if (out_free) begin
                            depth_next   = '0;
                            in_prog_next = 1'b0;
                            m_valid_next = 1'b1;
                            status_next  = STAT_DONE;
                            kind_next    = WALL_HORIZ;
                            wrow_next    = '0;
                            wcol_next    = '0;
                            crow_next    = '0;
                            ccol_next    = '0;
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        stk_rd_en  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    top_next.next = top_reg.next + 3'd1;
                    if (nb_try.in_grid) begin
                        dir_next   = cur_dir;
                        vis_rd_en  = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (vis_hit) begin
                    state_next = ST_TRY;
                end else if (out_free) begin
                    // carve: mark neighbor, save current frame, push neighbor
                    vis_wr_en                   = 1'b1;
                    vis_wdata[nb_chk.col]       = 1'b1;
                    row_valid_next[nb_chk.row]  = 1'b1;
                    stk_wr_en                   = 1'b1;
                    top_next.row                = nb_chk.row;
                    top_next.col                = nb_chk.col;
                    top_next.order              = ORDER_INIT;
                    top_next.next               = '0;
                    depth_next                  = depth_reg + DEPTH_W'(1);
                    m_valid_next                = 1'b1;
                    status_next                 = STAT_CARVED;
                    crow_next                   = nb_chk.row;
                    ccol_next                   = nb_chk.col;
                    if (!dir_reg[1]) begin
                        kind_next = WALL_HORIZ;
                        wrow_next = (dir_reg == DIR_DOWN) ? {1'b0, top_reg.row} + 5'd1
                                                          : {1'b0, top_reg.row};
                        wcol_next = {1'b0, top_reg.col};
                    end else begin
                        kind_next = WALL_VERT;
                        wrow_next = {1'b0, top_reg.row};
                        wcol_next = (dir_reg == DIR_LEFT) ? {1'b0, top_reg.col}
                                                          : {1'b0, top_reg.col} + 5'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                top_next   = stk_rdata;
                state_next = ST_TRY;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            in_prog_reg   <= 1'b0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            in_prog_reg   <= in_prog_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        dir_reg    <= dir_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        wrow_reg   <= wrow_next;
        wcol_reg   <= wcol_next;
        crow_reg   <= crow_next;
        ccol_reg   <= ccol_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {5'd0, ccol_reg, crow_reg, wcol_reg, wrow_reg, kind_reg};

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(CELL_CAP))
        else $error("stack depth beyond grid size");

    a_progress_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        in_prog_reg == (depth_reg != '0))
        else $error("in-progress flag disagrees with stack depth");

    a_load_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> $past(state_reg == ST_TRY)
                                 && depth_reg == $past(depth_reg) - DEPTH_W'(1))
        else $error("stack reload without a pop");

    a_carve_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && !vis_hit && out_free)
        |=> m_valid_reg && status_reg == STAT_CARVED
            && depth_reg == $past(depth_reg) + DEPTH_W'(1))
        else $error("carve did not push the new cell");

endmodule

// ===== hw/rtl/rmc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rmc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sim/rectangular_maze_carver_unit_tb.sv =====
// Self-checking testbench for the rectangular maze carver: requests, predictor and checks.
module rectangular_maze_carver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmc_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 64;
    localparam int SHOW_MAX     = 10;

    // One result as it leaves the block, fields from tuser and tdata.
    typedef struct packed {
        status_t    status;
        logic       wall_kind;
        logic [4:0] wall_row;
        logic [4:0] wall_col;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
    } carve_result_t;

    // Tracks the grid, the cell stack and the results still owed by the block.
    class maze_scoreboard;
        bit [GRID_COLS-1:0] visited [GRID_ROWS];
        frame_t             cell_stack [CELL_CAP];
        int unsigned        depth;
        bit                 busy;
        carve_result_t      pending[$];
        int                 mismatches;
        int                 n_checked;
        int                 n_carved;
        int                 n_finished;
        int                 n_ignored;
        int                 n_starts;

        function void push_cell(logic [3:0] r, logic [3:0] c);
            cell_stack[depth].row   = r;
            cell_stack[depth].col   = c;
            cell_stack[depth].order = {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};
            cell_stack[depth].next  = '0;
            depth = depth + 1;
            visited[r][c] = 1'b1;
        endfunction

        // Fisher-Yates over the four directions: slot 3, then 2, then 1.
        function order_t mix_order(logic [1:0] p3, logic [1:0] p2, logic p1);
            order_t     o;
            logic [1:0] held;
            logic [1:0] p2_sat;
            o[0] = DIR_UP;
            o[1] = DIR_DOWN;
            o[2] = DIR_LEFT;
            o[3] = DIR_RIGHT;
            p2_sat = (p2 > 2'd2) ? 2'd2 : p2;
            held = o[3]; o[3] = o[p3];       o[p3]       = held;
            held = o[2]; o[2] = o[p2_sat];   o[p2_sat]   = held;
            held = o[1]; o[1] = o[{1'b0, p1}]; o[{1'b0, p1}] = held;
            return o;
        endfunction

        // Walk the stack until an unvisited neighbor turns up, or the maze is done.
        function carve_result_t carve_next();
            frame_t        top;
            logic [1:0]    d;
            int            nr;
            int            nc;
            carve_result_t res;
            res        = '0;
            res.status = STAT_DONE;
            while (depth > 0) begin
                top = cell_stack[depth-1];
                while (top.next < 3'd4) begin
                    d        = top.order[top.next[1:0]];
                    top.next = top.next + 3'd1;
                    nr       = int'(top.row);
                    nc       = int'(top.col);
                    case (d)
                        DIR_UP:   nr = nr - 1;
                        DIR_DOWN: nr = nr + 1;
                        DIR_LEFT: nc = nc - 1;
                        default:  nc = nc + 1;
                    endcase
                    if (nr < 0 || nr >= GRID_ROWS || nc < 0 || nc >= GRID_COLS)
                        continue;
                    if (visited[nr][nc])
                        continue;
                    cell_stack[depth-1] = top;
                    res.status = STAT_CARVED;
                    if (d == DIR_UP || d == DIR_DOWN) begin
                        res.wall_kind = WALL_HORIZ;
                        res.wall_row  = 5'((nr > int'(top.row)) ? nr : int'(top.row));
                        res.wall_col  = 5'(top.col);
                    end else begin
                        res.wall_kind = WALL_VERT;
                        res.wall_row  = 5'(top.row);
                        res.wall_col  = (d == DIR_LEFT) ? 5'(top.col) : 5'(top.col) + 5'd1;
                    end
                    res.cell_row = 4'(nr);
                    res.cell_col = 4'(nc);
                    push_cell(4'(nr), 4'(nc));
                    return res;
                end
                depth = depth - 1;
            end
            busy = 1'b0;
            return res;
        endfunction

        function void note_request(logic req, logic [3:0] r, logic [3:0] c,
                                   logic [1:0] p3, logic [1:0] p2, logic p1);
            carve_result_t idle_res;
            if (req == REQ_START) begin
                if (r > GRID_ROWS - 1) r = 4'(GRID_ROWS - 1);
                if (c > GRID_COLS - 1) c = 4'(GRID_COLS - 1);
                foreach (visited[i]) visited[i] = '0;
                depth = 0;
                push_cell(r, c);
                cell_stack[0].order = mix_order(p3, p2, p1);
                busy = 1'b1;
                n_starts++;
                pending.push_back(carve_next());
            end else if (!busy || depth == 0) begin
                idle_res        = '0;
                idle_res.status = STAT_IGNORED;
                pending.push_back(idle_res);
            end else begin
                cell_stack[depth-1].order = mix_order(p3, p2, p1);
                cell_stack[depth-1].next  = '0;
                pending.push_back(carve_next());
            end
        endfunction

        function void check_result(carve_result_t got);
            carve_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("[%0t] unexpected result: status %0d, none pending",
                             $realtime, got.status);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            case (want.status)
                STAT_CARVED: n_carved++;
                STAT_DONE:   n_finished++;
                default:     n_ignored++;
            endcase
            if (got.status !== want.status || got.wall_kind !== want.wall_kind ||
                got.wall_row !== want.wall_row || got.wall_col !== want.wall_col ||
                got.cell_row !== want.cell_row || got.cell_col !== want.cell_col) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("[%0t] #%0d exp st=%0d kind=%0d wall=(%0d,%0d) cell=(%0d,%0d)",
                             $realtime, n_checked, want.status, want.wall_kind,
                             want.wall_row, want.wall_col, want.cell_row, want.cell_col);
                    $display("[%0t] #%0d got st=%0d kind=%0d wall=(%0d,%0d) cell=(%0d,%0d)",
                             $realtime, n_checked, got.status, got.wall_kind,
                             got.wall_row, got.wall_col, got.cell_row, got.cell_col);
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    maze_scoreboard sb = new;

    // Idle odds in percent for each side; the stimulus thread moves them per phase.
    int tx_idle_pct = 25;
    int rx_idle_pct = 59;
    int cycle_count = 0;

    rectangular_maze_carver_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop: a hung handshake must not let the run spin forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: drop tready at random according to the current phase.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: unpack every accepted result and hand it to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{status:    status_t'(m_tuser),
                              wall_kind: m_tdata[0],
                              wall_row:  m_tdata[5:1],
                              wall_col:  m_tdata[10:6],
                              cell_row:  m_tdata[14:11],
                              cell_col:  m_tdata[18:15]});
    end

    // Present one request, hold it until accepted, then tell the predictor.
    // tvalid stays high into the next request unless the sender decides to idle.
    task automatic send_request(input logic req, input logic [3:0] r, input logic [3:0] c,
                                input logic [1:0] p3, input logic [1:0] p2, input logic p1);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, p1, p2, p3, c, r};
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_request(req, r, c, p3, p2, p1);
    endtask

    // Shuffle request with random picks; pick_two covers its saturating value 3.
    task automatic send_shuffle();
        send_request(REQ_SHUFFLE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    task automatic send_start();
        send_request(REQ_START, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    initial begin
        int counted;
        counted = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a shuffle before any maze exists must be ignored.
        send_request(REQ_SHUFFLE, 4'd15, 4'd15, 2'd3, 2'd3, 1'b1);
        // Corner start, then each pick at its extremes, pick_two saturating at 3.
        send_request(REQ_START,   4'd0,  4'd0,  2'd0, 2'd0, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd3, 2'd2, 1'b1);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd0, 2'd3, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd1, 2'd1, 1'b1);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd2, 2'd0, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd3, 2'd3, 1'b1);
        // Restart in the opposite corner while the first maze is still open.
        send_request(REQ_START,   4'd15, 4'd15, 2'd3, 2'd3, 1'b1);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd0, 2'd0, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd1, 2'd2, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd2, 2'd1, 1'b1);
        send_request(REQ_START,   4'd0,  4'd15, 2'd1, 2'd0, 1'b1);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd3, 2'd0, 1'b1);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd0, 2'd2, 1'b1);
        send_request(REQ_START,   4'd15, 4'd0,  2'd2, 2'd2, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd1, 2'd3, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd3, 2'd1, 1'b1);
        send_request(REQ_START,   4'd8,  4'd7,  2'd0, 2'd1, 1'b0);
        send_request(REQ_SHUFFLE, 4'd0,  4'd0,  2'd2, 2'd3, 1'b1);

        // Random: mostly well-formed mazes run to completion, with rare restarts
        // and stray shuffles once a maze has finished.
        while (counted < RANDOM_ITEMS) begin
            if (counted == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 59;
                rx_idle_pct = 25;
            end else if (counted == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (sb.busy) begin
                if ($urandom_range(299) == 0)
                    send_start();
                else
                    send_shuffle();
                counted++;
            end else if ($urandom_range(7) == 0) begin
                // Ignored by the block, so it does not count.
                send_shuffle();
            end else begin
                send_start();
                counted++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays.
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d maze starts, %0d carved walls, %0d finished mazes,",
                 sb.n_starts, sb.n_carved, sb.n_finished);
        $display("%0d ignored shuffles; %0d results checked, %0d mismatches.",
                 sb.n_ignored, sb.n_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
